// ===== rtl/tlph_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-level perfect hash lookup package
// Shared codes, field widths, pipeline depths and beat structs.
// ----------------------------------------------------------------------------
package tlph_pkg;

  // command codes carried in in_tuser
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_LOAD_DESC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SLOT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE      = 2'd3;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_L1_MULT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_L1_ADD    = 2'd2;

  // field widths
  localparam int KEY_W  = 32;
  localparam int IDX_W  = 12;
  localparam int COEF_W = 31;
  localparam int SPAN_W = 12;
  localparam int BASE_W = 12;
  localparam int KC_W   = 11;
  localparam int HASH_W = 33;
  localparam int CFG_W  = 31;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 8;

  // hash modulus and the fold bias (sixteen times the modulus)
  localparam logic [HASH_W-1:0] HASH_PRIME = 33'd4294967311;
  localparam logic [36:0]       FOLD_BIAS  = 37'd68719476976;

  // pipeline depths
  localparam int HASH_LAT   = 4;
  localparam int REM_BPS    = 4;
  localparam int REM_STAGES = (HASH_W + REM_BPS - 1) / REM_BPS;
  localparam int PIPE_LAT   = HASH_LAT + REM_STAGES;

  // queue depths
  localparam int QDEPTH = 32;
  localparam int ODEPTH = 32;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int OCNT_W = $clog2(ODEPTH + 1);

  typedef struct packed {
    logic [KC_W-1:0]   key_count;
    logic [COEF_W-1:0] l1_mult;
    logic [COEF_W-1:0] l1_add;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  idx;
    logic [COEF_W-1:0] mult;
    logic [COEF_W-1:0] add;
    logic [SPAN_W-1:0] span;
    logic [BASE_W-1:0] base;
    logic              svalid;
  } in_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  idx;
    logic              svalid;
    logic              miss;
    logic [COEF_W-1:0] mult;
    logic [COEF_W-1:0] add;
    logic [SPAN_W-1:0] span;
    logic [BASE_W-1:0] base;
  } q_item_t;

endpackage

// ===== rtl/tlph_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tlph_fifo.sv =====
// ----------------------------------------------------------------------------
// Register FIFO
// Small first-in first-out buffer; the producer keeps count of free room.
// ----------------------------------------------------------------------------
module tlph_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;

  // store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= din;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign dout  = mem[rptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

// ===== rtl/tlph_hash.sv =====
// ----------------------------------------------------------------------------
// Prime hash pipeline
// (mult * key + add) mod 2^64, then mod 2^32+15, over four stages.
// ----------------------------------------------------------------------------
module tlph_hash
  import tlph_pkg::*;
(
  input  logic                    clk,
  input  logic [COEF_W-1:0]       mult,
  input  logic [COEF_W-1:0]       add,
  input  logic signed [KEY_W-1:0] key,
  output logic [HASH_W-1:0]       hash
);

  logic signed [63:0] prod_r;
  logic [COEF_W-1:0]  add_r;
  logic [63:0]        sum_r;
  logic [36:0]        fold_r;
  logic [HASH_W-1:0]  hash_r;
  logic [36:0]        hi37;
  logic [36:0]        fold_nxt;
  logic [33:0]        low_nxt;

  // stage 1: signed product
  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, mult}) * key;
    add_r  <= add;
  end

  // stage 2: wrapping sum
  always_ff @(posedge clk) begin
    sum_r <= $unsigned(prod_r) + 64'(add_r);
  end

  // stage 3: fold the high word, 2^32 is -15 modulo the prime
  always_comb begin
    hi37     = 37'(sum_r[63:32]);
    fold_nxt = 37'(sum_r[31:0]) + FOLD_BIAS - ((hi37 << 4) - hi37);
  end

  always_ff @(posedge clk) begin
    fold_r <= fold_nxt;
  end

  // stage 4: fold the small carry, then one conditional subtract
  always_comb begin
    low_nxt = 34'(fold_r[31:0]) + 34'(HASH_PRIME)
            - ((34'(fold_r[36:32]) << 4) - 34'(fold_r[36:32]));
  end

  always_ff @(posedge clk) begin
    if (low_nxt >= 34'(HASH_PRIME)) begin
      hash_r <= HASH_W'(low_nxt - 34'(HASH_PRIME));
    end else begin
      hash_r <= HASH_W'(low_nxt);
    end
  end

  assign hash = hash_r;

endmodule

// ===== rtl/tlph_rem.sv =====
// ----------------------------------------------------------------------------
// Pipelined remainder
// Restoring remainder, BPS dividend bits per stage, one item per cycle.
// ----------------------------------------------------------------------------
module tlph_rem #(
  parameter int DVD_W = 33,
  parameter int DIV_W = 11,
  parameter int BPS   = 4,
  localparam int NSTG  = (DVD_W + BPS - 1) / BPS,
  localparam int PAD_W = NSTG * BPS
) (
  input  logic             clk,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] remainder
);

  logic [PAD_W-1:0] dvd_r [1:NSTG];
  logic [DIV_W-1:0] rem_r [1:NSTG];
  logic [DIV_W-1:0] div_r [1:NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    logic [PAD_W-1:0] dvd_in;
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] div_in;
    logic [PAD_W-1:0] dvd_nxt;
    logic [DIV_W-1:0] rem_nxt;

    if (g == 0) begin : g_first
      assign dvd_in = PAD_W'(dividend);
      assign rem_in = '0;
      assign div_in = divisor;
    end else begin : g_next
      assign dvd_in = dvd_r[g];
      assign rem_in = rem_r[g];
      assign div_in = div_r[g];
    end

    // shift in one dividend bit per step, subtract when it fits
    always_comb begin
      logic [DIV_W:0] trial;
      dvd_nxt = dvd_in;
      rem_nxt = rem_in;
      for (int i = 0; i < BPS; i++) begin
        trial   = {rem_nxt, dvd_nxt[PAD_W-1]};
        dvd_nxt = dvd_nxt << 1;
        if (trial >= {1'b0, div_in}) begin
          trial = trial - {1'b0, div_in};
        end
        rem_nxt = trial[DIV_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      dvd_r[g+1] <= dvd_nxt;
      rem_r[g+1] <= rem_nxt;
      div_r[g+1] <= div_in;
    end
  end

  assign remainder = rem_r[NSTG];

endmodule

// ===== rtl/tlph_front.sv =====
// ----------------------------------------------------------------------------
// Lookup front end
// First-level hash, bucket select and descriptor store; feeds the queue.
// ----------------------------------------------------------------------------
module tlph_front
  import tlph_pkg::*;
#(
  parameter int MAX_KEYS = 1024,
  parameter int CLR_W    = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             item_valid,
  input  in_item_t         item,
  input  logic             clr_busy,
  input  logic [CLR_W-1:0] clr_addr,
  output logic             q_push,
  output q_item_t          q_item
);

  localparam int KAW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  logic                pv_r [0:PIPE_LAT];
  in_item_t            pd_r [0:PIPE_LAT];
  logic [HASH_W-1:0]   l1_hash;
  logic [KC_W-1:0]     bucket;
  in_item_t            d_item;
  logic                d_load;
  logic                d_miss;
  logic                ram_we;
  logic [KAW-1:0]      ram_waddr;
  logic [2*COEF_W-1:0] coef_wdata, coef_rdata;
  logic [SPAN_W+BASE_W-1:0] geo_wdata, geo_rdata;
  logic                d1_v_r;
  in_item_t            d1_r;
  logic                d1_miss_r;

  // carry beats alongside the hash and remainder pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= PIPE_LAT; i++) begin
        pv_r[i] <= 1'b0;
      end
    end else begin
      pv_r[0] <= item_valid;
      for (int i = 1; i <= PIPE_LAT; i++) begin
        pv_r[i] <= pv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    pd_r[0] <= item;
    for (int i = 1; i <= PIPE_LAT; i++) begin
      pd_r[i] <= pd_r[i-1];
    end
  end

  tlph_hash u_hash (
    .clk  (clk),
    .mult (cfg.l1_mult),
    .add  (cfg.l1_add),
    .key  ($signed(pd_r[0].key)),
    .hash (l1_hash)
  );

  tlph_rem #(
    .DVD_W (HASH_W),
    .DIV_W (KC_W),
    .BPS   (REM_BPS)
  ) u_rem (
    .clk       (clk),
    .dividend  (l1_hash),
    .divisor   (cfg.key_count),
    .remainder (bucket)
  );

  // descriptor stage: loads write, queries read, in beat order
  assign d_item = pd_r[PIPE_LAT];
  assign d_load = pv_r[PIPE_LAT] && (d_item.cmd == CMD_LOAD_DESC)
               && (32'(d_item.idx) < MAX_KEYS);
  assign d_miss = (cfg.key_count == '0) || (32'(bucket) >= MAX_KEYS);

  always_comb begin
    if (clr_busy) begin
      ram_we     = (32'(clr_addr) < MAX_KEYS);
      ram_waddr  = KAW'(clr_addr);
      coef_wdata = '0;
      geo_wdata  = '0;
    end else begin
      ram_we     = d_load;
      ram_waddr  = KAW'(d_item.idx);
      coef_wdata = {d_item.mult, d_item.add};
      geo_wdata  = {d_item.span, d_item.base};
    end
  end

  tlph_ram #(
    .WIDTH (2 * COEF_W),
    .DEPTH (MAX_KEYS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (coef_wdata),
    .raddr (KAW'(bucket)),
    .rdata (coef_rdata)
  );

  tlph_ram #(
    .WIDTH (SPAN_W + BASE_W),
    .DEPTH (MAX_KEYS)
  ) u_geo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (geo_wdata),
    .raddr (KAW'(bucket)),
    .rdata (geo_rdata)
  );

  // align the beat with the registered descriptor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
    end else begin
      d1_v_r <= pv_r[PIPE_LAT];
    end
  end

  always_ff @(posedge clk) begin
    d1_r      <= d_item;
    d1_miss_r <= d_miss;
  end

  assign q_push        = d1_v_r;
  assign q_item.cmd    = d1_r.cmd;
  assign q_item.key    = d1_r.key;
  assign q_item.idx    = d1_r.idx;
  assign q_item.svalid = d1_r.svalid;
  assign q_item.miss   = d1_miss_r;
  assign q_item.mult   = coef_rdata[2*COEF_W-1:COEF_W];
  assign q_item.add    = coef_rdata[COEF_W-1:0];
  assign q_item.span   = geo_rdata[SPAN_W+BASE_W-1:BASE_W];
  assign q_item.base   = geo_rdata[BASE_W-1:0];

endmodule

// ===== rtl/tlph_back.sv =====
// ----------------------------------------------------------------------------
// Lookup back end
// Second-level hash, slot store, key compare and result buffer.
// ----------------------------------------------------------------------------
module tlph_back
  import tlph_pkg::*;
#(
  parameter int SLOT_DEPTH = 4096,
  parameter int CLR_W      = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  q_item_t                q_head,
  output logic                   q_pop,
  input  logic                   clr_busy,
  input  logic [CLR_W-1:0]       clr_addr,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int SAW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

  logic                bv_r [0:PIPE_LAT];
  q_item_t             bd_r [0:PIPE_LAT];
  logic [OCNT_W-1:0]   oc_r;
  logic [HASH_W-1:0]   l2_hash;
  logic [SPAN_W-1:0]   offset;
  q_item_t             e_item;
  logic [BASE_W:0]     slot_addr;
  logic                e_miss;
  logic                slot_we;
  logic [SAW-1:0]      slot_waddr;
  logic [KEY_W:0]      slot_wdata, slot_rdata;
  logic                e1_q_r;
  logic                e1_miss_r;
  logic [KEY_W-1:0]    e1_key_r;
  logic                found;
  logic                out_pop;
  logic                of_empty;
  logic                of_dout;
  logic [OCNT_W-1:0]   of_count;

  // take a beat when the result buffer has room for it
  assign q_pop   = !q_empty && ((q_head.cmd != CMD_QUERY) || (oc_r < OCNT_W'(ODEPTH)));
  assign out_pop = out_tvalid && out_tready;

  // results owed to the output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r <= '0;
    end else if ((q_pop && (q_head.cmd == CMD_QUERY)) && !out_pop) begin
      oc_r <= oc_r + 1'b1;
    end else if (!(q_pop && (q_head.cmd == CMD_QUERY)) && out_pop) begin
      oc_r <= oc_r - 1'b1;
    end
  end

  // carry beats alongside the hash and remainder pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= PIPE_LAT; i++) begin
        bv_r[i] <= 1'b0;
      end
    end else begin
      bv_r[0] <= q_pop;
      for (int i = 1; i <= PIPE_LAT; i++) begin
        bv_r[i] <= bv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    bd_r[0] <= q_head;
    for (int i = 1; i <= PIPE_LAT; i++) begin
      bd_r[i] <= bd_r[i-1];
    end
  end

  tlph_hash u_hash (
    .clk  (clk),
    .mult (bd_r[0].mult),
    .add  (bd_r[0].add),
    .key  ($signed(bd_r[0].key)),
    .hash (l2_hash)
  );

  tlph_rem #(
    .DVD_W (HASH_W),
    .DIV_W (SPAN_W),
    .BPS   (REM_BPS)
  ) u_rem (
    .clk       (clk),
    .dividend  (l2_hash),
    .divisor   (bd_r[HASH_LAT].span),
    .remainder (offset)
  );

  // slot stage: slot loads write, queries read, in beat order
  assign e_item    = bd_r[PIPE_LAT];
  assign slot_addr = {1'b0, e_item.base} + (BASE_W + 1)'(offset);
  assign e_miss    = e_item.miss || (e_item.span == '0)
                  || (32'(slot_addr) >= SLOT_DEPTH);

  always_comb begin
    if (clr_busy) begin
      slot_we    = (32'(clr_addr) < SLOT_DEPTH);
      slot_waddr = SAW'(clr_addr);
      slot_wdata = '0;
    end else begin
      slot_we    = bv_r[PIPE_LAT] && (e_item.cmd == CMD_LOAD_SLOT)
                && (32'(e_item.idx) < SLOT_DEPTH);
      slot_waddr = SAW'(e_item.idx);
      slot_wdata = {e_item.svalid, e_item.key};
    end
  end

  tlph_ram #(
    .WIDTH (KEY_W + 1),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (SAW'(slot_addr)),
    .rdata (slot_rdata)
  );

  // compare against the registered slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_q_r <= 1'b0;
    end else begin
      e1_q_r <= bv_r[PIPE_LAT] && (e_item.cmd == CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    e1_miss_r <= e_miss;
    e1_key_r  <= e_item.key;
  end

  assign found = !e1_miss_r && slot_rdata[KEY_W] && (slot_rdata[KEY_W-1:0] == e1_key_r);

  tlph_fifo #(
    .WIDTH (1),
    .DEPTH (ODEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (e1_q_r),
    .din   (found),
    .pop   (out_pop),
    .dout  (of_dout),
    .empty (of_empty),
    .count (of_count)
  );

  assign out_tvalid = !of_empty;
  assign out_tdata  = {(OUT_TDATA_W - 1)'(0), of_dout};

`ifndef SYNTHESIS
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    e1_q_r |-> (of_count < OCNT_W'(ODEPTH)))
    else $error("result pushed into a full output buffer");

  a_owed_covers: assert property (@(posedge clk) disable iff (!rst_n)
    of_count <= oc_r)
    else $error("output buffer holds more than the owed count");
`endif

endmodule

// ===== rtl/two_level_perfect_hash_lookup.sv =====
// ----------------------------------------------------------------------------
// Two-level perfect hash lookup
// Membership test against a static two-level hash set loaded by commands.
// ----------------------------------------------------------------------------
// Usage: beats arrive on in_* (tuser is the command). Descriptor and slot
// loads update the tables and give no result; a query gives one out_* beat
// whose bit 0 is the found flag. Command 3 beats are taken and dropped.
// Throughput: one beat per cycle while in_tready is high; the front
// hash/remainder pipeline runs a beat per cycle and the back one too while
// its result buffer has room, the two coupled by a 32-entry queue.
// Reset: registers go to key_count 0, multiplier 1, adder 1; a clearing
// pass then sweeps the descriptor and slot stores over max(MAX_KEYS,
// SLOT_DEPTH) addresses (4096 by default) with in_tready low.
// Stalls: when out_tready is low, results collect in a 32-entry buffer,
// the back end stops taking query beats once that room is promised, and
// in_tready falls when the queue plus the front pipeline is full.
// Configuration writes on cfg_* are taken at any time but should only be
// made while no query is in flight.
// ----------------------------------------------------------------------------
module two_level_perfect_hash_lookup
  import tlph_pkg::*;
#(
  parameter int MAX_KEYS   = 1024,
  parameter int SLOT_DEPTH = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // key [31:0], entry_index [43:32], bucket_mult [74:44], bucket_add [105:75],
  // bucket_span [117:106], bucket_base [129:118], slot_valid [130]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command [1:0]
  input  logic [CMD_W-1:0]       in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // found [0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [REG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int CLR_DEPTH = (MAX_KEYS > SLOT_DEPTH) ? MAX_KEYS : SLOT_DEPTH;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  cfg_t                cfg_r;
  logic                clr_busy_r;
  logic [CLR_W-1:0]    clr_addr_r;
  logic [QCNT_W-1:0]   fc_r;
  in_item_t            in_item;
  logic                in_beat;
  logic                in_take;
  logic                q_push;
  q_item_t             q_din;
  logic                q_pop;
  logic                q_empty;
  logic [QCNT_W-1:0]   q_count;
  logic [$bits(q_item_t)-1:0] q_dout;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_count <= '0;
      cfg_r.l1_mult   <= COEF_W'(1);
      cfg_r.l1_add    <= COEF_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KEY_COUNT: cfg_r.key_count <= cfg_wdata[KC_W-1:0];
        REG_L1_MULT:   cfg_r.l1_mult   <= cfg_wdata[COEF_W-1:0];
        REG_L1_ADD:    cfg_r.l1_add    <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == CLR_W'(CLR_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // unpack the input beat
  assign in_item.cmd    = in_tuser;
  assign in_item.key    = in_tdata[31:0];
  assign in_item.idx    = in_tdata[43:32];
  assign in_item.mult   = in_tdata[74:44];
  assign in_item.add    = in_tdata[105:75];
  assign in_item.span   = in_tdata[117:106];
  assign in_item.base   = in_tdata[129:118];
  assign in_item.svalid = in_tdata[130];

  // accept while the queue can absorb everything in the front pipeline
  assign in_tready = !clr_busy_r && (fc_r < QCNT_W'(QDEPTH));
  assign in_beat   = in_tvalid && in_tready;
  assign in_take   = in_beat && (in_tuser != CMD_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= '0;
    end else if (in_take && !q_pop) begin
      fc_r <= fc_r + 1'b1;
    end else if (!in_take && q_pop) begin
      fc_r <= fc_r - 1'b1;
    end
  end

  tlph_front #(
    .MAX_KEYS (MAX_KEYS),
    .CLR_W    (CLR_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (in_take),
    .item       (in_item),
    .clr_busy   (clr_busy_r),
    .clr_addr   (clr_addr_r),
    .q_push     (q_push),
    .q_item     (q_din)
  );

  tlph_fifo #(
    .WIDTH ($bits(q_item_t)),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_count)
  );

  tlph_back #(
    .SLOT_DEPTH (SLOT_DEPTH),
    .CLR_W      (CLR_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_item_t'(q_dout)),
    .q_pop      (q_pop),
    .clr_busy   (clr_busy_r),
    .clr_addr   (clr_addr_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready)
    else $error("input taken during the clearing pass");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count < QCNT_W'(QDEPTH)) || q_pop)
    else $error("beat pushed into a full queue");

  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> ($past(clr_addr_r) == CLR_W'(CLR_DEPTH - 1)))
    else $error("clearing pass ended early");
`endif

endmodule

// ===== verif/two_level_perfect_hash_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// Two-level perfect hash lookup testbench
// Loads descriptor and slot tables, queries keys against a local copy of the
// tables, and checks each found flag in order under random stalls and
// backpressure on both streams.
// ----------------------------------------------------------------------------
module two_level_perfect_hash_lookup_tb;
  import tlph_pkg::*;

  localparam int NKEYS     = 1024;
  localparam int NSLOTS    = 4096;
  localparam int DRAIN_CYC = 48;
  localparam int WD_LIMIT  = 20000;
  localparam int HOLD_CYC  = 400;
  localparam logic [63:0] PRIME64 = 64'd4294967311;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]       in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [REG_IDX_W-1:0]   cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;

  two_level_perfect_hash_lookup u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // shadow tables and registers
  logic [COEF_W-1:0] desc_mult [NKEYS];
  logic [COEF_W-1:0] desc_add  [NKEYS];
  logic [SPAN_W-1:0] desc_span [NKEYS];
  logic [BASE_W-1:0] desc_base [NKEYS];
  logic [KEY_W-1:0]  slot_key  [NSLOTS];
  bit                slot_vld  [NSLOTS];
  logic [KC_W-1:0]   shadow_kc;
  logic [COEF_W-1:0] shadow_mult;
  logic [COEF_W-1:0] shadow_add;

  bit   found_q [$];
  int   errors;
  int   beats_sent;
  int   idle_cycles;
  bit   calm;
  bit   hold_req;
  int   hold_left;
  int   rx_gap;
  logic [KEY_W-1:0] known_keys [$];

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ((mult * sign-extended key + add) mod 2^64) mod prime
  function automatic logic [63:0] prime_hash(logic [COEF_W-1:0] m, logic [COEF_W-1:0] a,
                                             logic [KEY_W-1:0] k);
    logic [63:0] wide;
    logic [63:0] sum;
    wide = {{32{k[31]}}, k};
    sum  = {33'd0, m} * wide + {33'd0, a};
    return sum % PRIME64;
  endfunction

  function automatic logic [63:0] level1_bucket(logic [KEY_W-1:0] k);
    return prime_hash(shadow_mult, shadow_add, k) % {53'd0, shadow_kc};
  endfunction

  function automatic logic [63:0] slot_addr(int b, logic [KEY_W-1:0] k);
    return {52'd0, desc_base[b]}
         + prime_hash(desc_mult[b], desc_add[b], k) % {52'd0, desc_span[b]};
  endfunction

  function automatic bit predict_found(logic [KEY_W-1:0] k);
    logic [63:0] b;
    logic [63:0] addr;
    if (shadow_kc == 0) return 1'b0;
    b = level1_bucket(k);
    if (b >= NKEYS) return 1'b0;
    if (desc_span[b] == 0) return 1'b0;
    addr = slot_addr(int'(b), k);
    if (addr >= NSLOTS) return 1'b0;
    return slot_vld[addr] && slot_key[addr] == k;
  endfunction

  // send one beat, then update the shadow tables once it is taken
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k, logic [IDX_W-1:0] idx,
                           logic [COEF_W-1:0] m, logic [COEF_W-1:0] a,
                           logic [SPAN_W-1:0] span, logic [BASE_W-1:0] base, bit sv);
    int gap;
    in_tuser  <= cmd;
    in_tdata  <= {5'd0, sv, base, span, a, m, idx, k};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    case (cmd)
      CMD_LOAD_DESC: begin
        if (idx < NKEYS) begin
          desc_mult[idx] = m;
          desc_add[idx]  = a;
          desc_span[idx] = span;
          desc_base[idx] = base;
        end
      end
      CMD_LOAD_SLOT: begin
        slot_key[idx] = k;
        slot_vld[idx] = sv;
      end
      CMD_QUERY: found_q = {found_q, predict_found(k)};
      default: ;
    endcase
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic query(logic [KEY_W-1:0] k);
    send_beat(CMD_QUERY, k, IDX_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
              SPAN_W'($urandom), BASE_W'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (found_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // drive one register write; the caller drops the write enable
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_KEY_COUNT: shadow_kc   = val[KC_W-1:0];
      REG_L1_MULT:   shadow_mult = val[COEF_W-1:0];
      REG_L1_ADD:    shadow_add  = val[COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_hash(logic [KC_W-1:0] kc, logic [COEF_W-1:0] m, logic [COEF_W-1:0] a);
    wait_drained();
    write_reg(REG_KEY_COUNT, CFG_W'(kc));
    write_reg(REG_L1_MULT, m);
    write_reg(REG_L1_ADD, a);
    cfg_we <= 1'b0;
  endtask

  // place a key: give its bucket a descriptor if empty, store it, query it
  task automatic insert_and_query(logic [KEY_W-1:0] k, bit valid_slot);
    logic [63:0] b;
    logic [63:0] addr;
    b = level1_bucket(k);
    if (b < NKEYS) begin
      if (desc_span[b] == 0)
        send_beat(CMD_LOAD_DESC, $urandom, IDX_W'(b), COEF_W'($urandom), COEF_W'($urandom),
                  SPAN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(17, 256)
                                                      : $urandom_range(1, 16)),
                  BASE_W'(($urandom_range(0, 19) == 0) ? $urandom_range(4000, 4095)
                                                       : $urandom_range(0, 3800)),
                  1'($urandom));
      addr = slot_addr(int'(b), k);
      if (addr < NSLOTS)
        send_beat(CMD_LOAD_SLOT, k, IDX_W'(addr), COEF_W'($urandom), COEF_W'($urandom),
                  SPAN_W'($urandom), BASE_W'($urandom), valid_slot);
    end
    known_keys = {known_keys, k};
    query(k);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 255);
      1: return -$urandom_range(1, 255);
      default: return $urandom;
    endcase
  endfunction

  // empty set after reset, extreme keys
  task automatic test_empty_set();
    query(32'h8000_0000);
    query(32'h7FFF_FFFF);
    query(32'h0000_0000);
    query(32'hFFFF_FFFF);
  endtask

  // loads, ignored commands, empty bucket, slot beyond the store
  task automatic test_directed();
    set_hash(11'd1, 31'd1, 31'd1);
    // single bucket, extreme keys stored and queried
    send_beat(CMD_LOAD_DESC, 0, 12'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 12'd16, 12'd0, 1'b0);
    insert_and_query(32'h8000_0000, 1'b1);
    insert_and_query(32'h7FFF_FFFF, 1'b1);
    insert_and_query(32'hFFFF_FFFF, 1'b1);
    insert_and_query(32'h0000_0000, 1'b0);
    // descriptor load beyond the store is ignored
    send_beat(CMD_LOAD_DESC, 0, 12'hFFF, 31'd5, 31'd7, 12'd0, 12'd0, 1'b1);
    send_beat(CMD_LOAD_DESC, 0, 12'd1024, 31'd5, 31'd7, 12'd0, 12'd0, 1'b1);
    query(32'h8000_0000);
    // unused command is dropped
    send_beat(CMD_NONE, 32'h8000_0000, 12'd0, 31'd1, 31'd1, 12'd0, 12'd0, 1'b0);
    query(32'h7FFF_FFFF);
    // empty bucket
    send_beat(CMD_LOAD_DESC, 0, 12'd0, 31'd1, 31'd1, 12'd0, 12'd0, 1'b0);
    query(32'h7FFF_FFFF);
    // slot beyond the store
    send_beat(CMD_LOAD_DESC, 0, 12'd0, 31'd3, 31'd9, 12'hFFF, 12'hFFF, 1'b0);
    query(32'h1234_5678);
    query(32'h8765_4321);
    // last slot address, full width slot load
    send_beat(CMD_LOAD_SLOT, 32'hFFFF_FFFF, 12'hFFF, '0, '0, '0, '0, 1'b1);
    // key count beyond the descriptor store
    set_hash(11'h7FF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    for (int i = 0; i < 4; i++) query($urandom);
  endtask

  // random tables under several hash settings
  task automatic test_random_sets();
    logic [KC_W-1:0] kc;
    int goal;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: kc = 11'd1024;
        1: kc = 11'd1;
        2: kc = 11'h7FF;
        default: kc = KC_W'($urandom_range(2, 64));
      endcase
      calm = (ph == 3);
      set_hash(kc, (ph == 1) ? 31'd1 : COEF_W'($urandom),
               (ph == 4) ? 31'h7FFF_FFFF : COEF_W'($urandom));
      goal = beats_sent + 270;
      while (beats_sent < goal) begin
        case ($urandom_range(0, 9))
          0: send_beat(CMD_W'($urandom), $urandom, IDX_W'($urandom), COEF_W'($urandom),
                       COEF_W'($urandom), SPAN_W'($urandom), BASE_W'($urandom),
                       1'($urandom));
          1: query(rand_key());
          2: if (known_keys.size() > 0)
               query(known_keys[$urandom_range(0, known_keys.size() - 1)]);
          default: insert_and_query(rand_key(), $urandom_range(0, 7) != 0);
        endcase
      end
      calm = 1'b0;
    end
  endtask

  // hold the receiver off while the sender keeps offering queries
  task automatic test_backpressure();
    wait_drained();
    calm     = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 150; i++) begin
      if (known_keys.size() > 0 && $urandom_range(0, 1))
        query(known_keys[$urandom_range(0, known_keys.size() - 1)]);
      else
        query(rand_key());
    end
    calm = 1'b0;
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      out_tready <= 1'b0;
      hold_left = hold_left + 1;
      if (hold_left >= HOLD_CYC) begin
        hold_req  = 1'b0;
        hold_left = 0;
      end
    end else if (rx_gap > 0) begin
      out_tready <= 1'b0;
      rx_gap = rx_gap - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (found_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual found=%0b",
                 $realtime, out_tdata[0]);
        errors++;
      end else begin
        if (out_tdata[0] !== found_q[0]) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $realtime, found_q[0], out_tdata[0]);
          errors++;
        end
        void'(found_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    in_tvalid   = 1'b0;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    errors      = 0;
    beats_sent  = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    rx_gap      = 0;
    shadow_kc   = '0;
    shadow_mult = 31'd1;
    shadow_add  = 31'd1;
    for (int i = 0; i < NKEYS; i++) begin
      desc_mult[i] = '0;
      desc_add[i]  = '0;
      desc_span[i] = '0;
      desc_base[i] = '0;
    end
    for (int i = 0; i < NSLOTS; i++) begin
      slot_key[i] = '0;
      slot_vld[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_set();
    test_directed();
    test_random_sets();
    test_backpressure();
    wait_drained();

    if (errors == 0 && found_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
